// File: rtl/sps_pkg.sv
// shared types, codes and constants for the sensor poll sequencer
package sps_pkg;

    localparam int unsigned RAW20_W = 20;
    localparam int unsigned PRESS_W = 14;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned RX_W    = 48;

    localparam logic [RAW20_W-1:0] BARO_MIN_RST = 20'd0;
    localparam logic [RAW20_W-1:0] BARO_MAX_RST = 20'd1048560;
    localparam logic [RAW20_W-1:0] TEMP_MIN_RST = 20'd0;
    localparam logic [RAW20_W-1:0] TEMP_MAX_RST = 20'd1048560;

    localparam logic [7:0] NO_DATA_BYTE = 8'hFF;

    // bus operation codes as seen on the result port
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_FLOW_REQ   = 3'd1,
        OP_FLOW_READ  = 3'd2,
        OP_PRESS_READ = 3'd3,
        OP_BARO_ADDR  = 3'd4,
        OP_BARO_READ  = 3'd5
    } t_op;

    // transfer outcome codes
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_NACK  = 2'd1,
        ERR_OTHER = 2'd2,
        ERR_SPARE = 2'd3
    } t_err;

    // event codes
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_DONE  = 1'b1
    } t_func;

    // config register indexes
    typedef enum logic [1:0] {
        CFG_BARO_MIN = 2'd0,
        CFG_BARO_MAX = 2'd1,
        CFG_TEMP_MIN = 2'd2,
        CFG_TEMP_MAX = 2'd3
    } t_cfg_idx;

    // operation in flight, one-hot
    typedef enum logic [5:0] {
        PH_STOPPED    = 6'b000001,
        PH_FLOW_REQ   = 6'b000010,
        PH_FLOW_READ  = 6'b000100,
        PH_PRESS_READ = 6'b001000,
        PH_BARO_ADDR  = 6'b010000,
        PH_BARO_READ  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [RAW20_W-1:0] baro_min;
        logic [RAW20_W-1:0] baro_max;
        logic [RAW20_W-1:0] temp_min;
        logic [RAW20_W-1:0] temp_max;
    } t_cfg;

    typedef struct packed {
        t_op                next_op;
        logic               press_valid;
        logic [PRESS_W-1:0] press_raw;
        logic [TIME_W-1:0]  press_dt_us;
        logic               flow_valid;
        logic signed [15:0] flow_raw;
        logic [TIME_W-1:0]  flow_dt_us;
        logic               baro_valid;
        logic [RAW20_W-1:0] baro_raw;
        logic               temp_valid;
        logic [RAW20_W-1:0] temp_raw;
    } t_result;

    function automatic t_phase op_to_phase(input t_op op);
        t_phase ph;
        unique case (op)
            OP_FLOW_REQ:   ph = PH_FLOW_REQ;
            OP_FLOW_READ:  ph = PH_FLOW_READ;
            OP_PRESS_READ: ph = PH_PRESS_READ;
            OP_BARO_ADDR:  ph = PH_BARO_ADDR;
            OP_BARO_READ:  ph = PH_BARO_READ;
            default:       ph = PH_STOPPED;
        endcase
        return ph;
    endfunction

endpackage

// File: rtl/sps_cfg_regs.sv
// range limit registers written over the config port
module sps_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [19:0]         i_cfg_data,
    output logic                o_cfg_ready,
    output sps_pkg::t_cfg       o_cfg
);

    sps_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baro_min <= sps_pkg::BARO_MIN_RST;
            r_cfg.baro_max <= sps_pkg::BARO_MAX_RST;
            r_cfg.temp_min <= sps_pkg::TEMP_MIN_RST;
            r_cfg.temp_max <= sps_pkg::TEMP_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (sps_pkg::t_cfg_idx'(i_cfg_index))
                sps_pkg::CFG_BARO_MIN: r_cfg.baro_min <= i_cfg_data;
                sps_pkg::CFG_BARO_MAX: r_cfg.baro_max <= i_cfg_data;
                sps_pkg::CFG_TEMP_MIN: r_cfg.temp_min <= i_cfg_data;
                sps_pkg::CFG_TEMP_MAX: r_cfg.temp_max <= i_cfg_data;
                default:               r_cfg        <= r_cfg;
            endcase
        end
    end

endmodule

// File: rtl/sps_step.sv
// next-operation decision and sample extraction for one event
module sps_step (
    input  sps_pkg::t_phase     i_phase,
    input  logic [15:0]         i_last_press,
    input  logic [15:0]         i_last_flow,
    input  sps_pkg::t_cfg       i_cfg,
    input  logic                i_func,
    input  logic [1:0]          i_err_class,
    input  logic [47:0]         i_rx_data,
    input  logic [15:0]         i_now_us,
    output sps_pkg::t_result    o_res,
    output sps_pkg::t_phase     o_phase,
    output logic [15:0]         o_last_press,
    output logic [15:0]         o_last_flow
);

    logic [7:0]  b0, b1, b2, b3, b4, b5;
    logic [19:0] baro_p;
    logic [19:0] temp_t;
    logic        err_none;
    logic        err_nack;
    logic        no_data;

    assign b0 = i_rx_data[47:40];
    assign b1 = i_rx_data[39:32];
    assign b2 = i_rx_data[31:24];
    assign b3 = i_rx_data[23:16];
    assign b4 = i_rx_data[15:8];
    assign b5 = i_rx_data[7:0];

    assign baro_p   = {b0, b1, b2[7:4]};
    assign temp_t   = {b3, b4, b5[7:4]};
    assign err_none = (sps_pkg::t_err'(i_err_class) == sps_pkg::ERR_NONE);
    assign err_nack = (sps_pkg::t_err'(i_err_class) == sps_pkg::ERR_NACK);
    assign no_data  = (b0 == sps_pkg::NO_DATA_BYTE) && (b1 == sps_pkg::NO_DATA_BYTE)
                   && (b2 == sps_pkg::NO_DATA_BYTE);

    always_comb begin
        o_res        = '0;
        o_res.next_op = sps_pkg::OP_NONE;
        o_last_press = i_last_press;
        o_last_flow  = i_last_flow;

        if (sps_pkg::t_func'(i_func) == sps_pkg::FUNC_START) begin
            o_res.next_op = sps_pkg::OP_FLOW_REQ;
        end else begin
            unique case (i_phase)
                sps_pkg::PH_PRESS_READ: begin
                    if (err_nack) begin
                        o_res.next_op = sps_pkg::OP_PRESS_READ;
                    end else begin
                        // status bits must be clear for a usable sample
                        if (err_none && (b0[7:6] == 2'b00)) begin
                            o_res.press_valid = 1'b1;
                            o_res.press_raw   = {b0[5:0], b1};
                            o_res.press_dt_us = i_now_us - i_last_press;
                            o_last_press      = i_now_us;
                        end
                        o_res.next_op = sps_pkg::OP_FLOW_READ;
                    end
                end
                sps_pkg::PH_FLOW_REQ: begin
                    o_res.next_op = err_nack ? sps_pkg::OP_FLOW_REQ : sps_pkg::OP_FLOW_READ;
                end
                sps_pkg::PH_FLOW_READ: begin
                    if (err_nack) begin
                        o_res.next_op = sps_pkg::OP_PRESS_READ;
                    end else if (!err_none || no_data) begin
                        o_res.next_op = sps_pkg::OP_BARO_ADDR;
                    end else begin
                        o_res.flow_valid = 1'b1;
                        o_res.flow_raw   = {b0, b1};
                        o_res.flow_dt_us = i_now_us - i_last_flow;
                        o_last_flow      = i_now_us;
                        o_res.next_op    = sps_pkg::OP_FLOW_READ;
                    end
                end
                sps_pkg::PH_BARO_ADDR: begin
                    o_res.next_op = sps_pkg::OP_BARO_READ;
                end
                sps_pkg::PH_BARO_READ: begin
                    o_res.baro_raw   = baro_p;
                    o_res.temp_raw   = temp_t;
                    o_res.baro_valid = (baro_p > i_cfg.baro_min) && (baro_p < i_cfg.baro_max);
                    o_res.temp_valid = (temp_t > i_cfg.temp_min) && (temp_t < i_cfg.temp_max);
                    o_res.next_op    = sps_pkg::OP_PRESS_READ;
                end
                default: begin
                    o_res.next_op = sps_pkg::OP_NONE;
                end
            endcase
        end

        // a completion while stopped leaves the phase alone
        o_phase = (o_res.next_op == sps_pkg::OP_NONE) ? i_phase
                                                      : sps_pkg::op_to_phase(o_res.next_op);
    end

endmodule

// File: rtl/sensor_poll_sequencer_core.sv
// top level of the sensor poll sequencer: event register, step logic, result register
//
// usage
// - event channel (i_in_valid / o_in_stall): one beat per start or transfer-completion
//   event, carrying func, err_class, rx_data and now_us
// - result channel (o_out_valid / i_out_stall): one beat per event, giving the next
//   bus operation and any raw pressure, flow, barometer and temperature sample
// - config channel (i_cfg_valid / o_cfg_ready): writes the four 20-bit range limits;
//   ready is always high, writes are meant for idle periods only
// - an accepted event waits in the event register, and its result is loaded into the
//   result register once that register is free or draining
// - throughput: one event per cycle while the receiver does not stall; the event register and the result register each
//   hold one beat, and the sequencer state advances when a beat crosses between them
// - when the receiver stalls, the result register holds its beat, the event register
//   keeps its beat, and o_in_stall rises only once both are full
// - reset (synchronous, active low): the sequencer is stopped, both sample timestamps
//   are zero, the limits take their defaults and both registers are empty
module sensor_poll_sequencer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [1:0]         i_err_class,
    input  logic [47:0]        i_rx_data,
    input  logic [15:0]        i_now_us,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_next_op,
    output logic               o_press_valid,
    output logic [13:0]        o_press_raw,
    output logic [15:0]        o_press_dt_us,
    output logic               o_flow_valid,
    output logic signed [15:0] o_flow_raw,
    output logic [15:0]        o_flow_dt_us,
    output logic               o_baro_valid,
    output logic [19:0]        o_baro_raw,
    output logic               o_temp_valid,
    output logic [19:0]        o_temp_raw,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    // event register
    logic               r_in_vld;
    logic               r_func;
    logic [1:0]         r_err_class;
    logic [47:0]        r_rx_data;
    logic [15:0]        r_now_us;

    // sequencer state
    sps_pkg::t_phase    r_phase;
    sps_pkg::t_phase    n_phase;
    logic [15:0]        r_last_press;
    logic [15:0]        n_last_press;
    logic [15:0]        r_last_flow;
    logic [15:0]        n_last_flow;

    // result register
    logic               r_out_vld;
    sps_pkg::t_result   r_res;
    sps_pkg::t_result   n_res;

    sps_pkg::t_cfg      cfg;
    logic               advance;
    logic               in_take;

    // event beat moves to the result register when that one is free or draining
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    sps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    sps_step u_step (
        .i_phase      (r_phase),
        .i_last_press (r_last_press),
        .i_last_flow  (r_last_flow),
        .i_cfg        (cfg),
        .i_func       (r_func),
        .i_err_class  (r_err_class),
        .i_rx_data    (r_rx_data),
        .i_now_us     (r_now_us),
        .o_res        (n_res),
        .o_phase      (n_phase),
        .o_last_press (n_last_press),
        .o_last_flow  (n_last_flow)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_phase      <= sps_pkg::PH_STOPPED;
            r_last_press <= '0;
            r_last_flow  <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                r_out_vld    <= 1'b1;
                r_phase      <= n_phase;
                r_last_press <= n_last_press;
                r_last_flow  <= n_last_flow;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func      <= i_func;
            r_err_class <= i_err_class;
            r_rx_data   <= i_rx_data;
            r_now_us    <= i_now_us;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_next_op     = r_res.next_op;
    assign o_press_valid = r_res.press_valid;
    assign o_press_raw   = r_res.press_raw;
    assign o_press_dt_us = r_res.press_dt_us;
    assign o_flow_valid  = r_res.flow_valid;
    assign o_flow_raw    = r_res.flow_raw;
    assign o_flow_dt_us  = r_res.flow_dt_us;
    assign o_baro_valid  = r_res.baro_valid;
    assign o_baro_raw    = r_res.baro_raw;
    assign o_temp_valid  = r_res.temp_valid;
    assign o_temp_raw    = r_res.temp_raw;

    // at most one sensor produces a sample per beat
    a_one_sensor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_press_valid, o_flow_valid,
                                    o_baro_valid || o_temp_valid}) <= 1)
        else $error("samples from more than one sensor in one beat");

    // no operation means no sample
    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_next_op == sps_pkg::OP_NONE)) |->
            (!o_press_valid && !o_flow_valid && !o_baro_valid && !o_temp_valid))
        else $error("sample reported with no next operation");

    // interval fields are zero without a sample
    a_dt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_press_valid || (o_press_dt_us == '0))
                      && (o_flow_valid || (o_flow_dt_us == '0))))
        else $error("interval reported without a sample");

    // the stored phase follows the operation handed out
    a_phase_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_res.next_op != sps_pkg::OP_NONE)) |=>
            (r_phase == sps_pkg::op_to_phase(sps_pkg::t_op'(o_next_op))))
        else $error("phase does not match last operation");

    // a stalled result with a waiting event blocks the event channel
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("event taken while both registers are full");

endmodule
